FILE: sv/mvsd_pkg.sv
// Package for the virtual address segment decoder: segment codes, status bit
// positions, privilege masks and the constant segment descriptor table.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mvsd_pkg;

    localparam int VADDR_W  = 64;
    localparam int STATUS_W = 8;
    localparam int SEG_ID_W = 4;
    localparam int MASK_W   = 8;

    localparam logic [SEG_ID_W-1:0] SEG_USEG32 = 4'd0;
    localparam logic [SEG_ID_W-1:0] SEG_XUSEG  = 4'd1;
    localparam logic [SEG_ID_W-1:0] SEG_XSSEG  = 4'd2;
    localparam logic [SEG_ID_W-1:0] SEG_CKSEG0 = 4'd3;
    localparam logic [SEG_ID_W-1:0] SEG_CKSEG1 = 4'd4;
    localparam logic [SEG_ID_W-1:0] SEG_CKSSEG = 4'd5;
    localparam logic [SEG_ID_W-1:0] SEG_CKSEG3 = 4'd6;
    localparam logic [SEG_ID_W-1:0] SEG_XKSEG  = 4'd7;
    localparam logic [SEG_ID_W-1:0] SEG_XKPHYS = 4'd8;

    localparam int ST_KX = 7;
    localparam int ST_SX = 6;
    localparam int ST_UX = 5;

    // KSU, ERL, EXL as one field (status bits 4..1)
    localparam logic [3:0] MODE_USER = 4'b1000;
    localparam logic [3:0] MODE_SUP  = 4'b0100;
    localparam logic [3:0] MODE_RSVD = 4'b1100;

    localparam logic [MASK_W-1:0] PRIV_USER = 8'h20;
    localparam logic [MASK_W-1:0] PRIV_SUP  = 8'h40;
    localparam logic [MASK_W-1:0] PRIV_KERN = 8'h80;

    typedef struct packed {
        logic [VADDR_W-1:0] offset;
        logic [MASK_W-1:0]  mask;
        logic               mapped;
        logic               cached;
    } seg_desc_t;

    typedef struct packed {
        logic                hit;
        logic [SEG_ID_W-1:0] seg_id;
        seg_desc_t           desc;
    } seg_result_t;

    function automatic seg_desc_t seg_desc(input logic [SEG_ID_W-1:0] id);
        seg_desc_t d;
        unique case (id)
            4'd0:    d = '{64'h0, PRIV_USER, 1'b1, 1'b1};
            4'd1:    d = '{64'h0, PRIV_USER, 1'b1, 1'b1};
            4'd2:    d = '{64'h0, PRIV_SUP,  1'b1, 1'b1};
            4'd3:    d = '{64'hFFFF_FFFF_8000_0000, PRIV_KERN, 1'b0, 1'b1};
            4'd4:    d = '{64'hFFFF_FFFF_A000_0000, PRIV_KERN, 1'b0, 1'b0};
            4'd5:    d = '{64'h0, PRIV_KERN, 1'b1, 1'b1};
            4'd6:    d = '{64'h0, PRIV_KERN, 1'b1, 1'b1};
            4'd7:    d = '{64'h0, PRIV_KERN, 1'b1, 1'b1};
            4'd8:    d = '{64'h8000_0000_0000_0000, PRIV_KERN, 1'b0, 1'b1};
            4'd9:    d = '{64'h8800_0000_0000_0000, PRIV_KERN, 1'b0, 1'b1};
            4'd10:   d = '{64'h9000_0000_0000_0000, PRIV_KERN, 1'b0, 1'b0};
            4'd11:   d = '{64'h9800_0000_0000_0000, PRIV_KERN, 1'b0, 1'b1};
            4'd12:   d = '{64'hA000_0000_0000_0000, PRIV_KERN, 1'b0, 1'b1};
            4'd13:   d = '{64'hA800_0000_0000_0000, PRIV_KERN, 1'b0, 1'b1};
            4'd14:   d = '{64'hB000_0000_0000_0000, PRIV_KERN, 1'b0, 1'b1};
            default: d = '{64'hB800_0000_0000_0000, PRIV_KERN, 1'b0, 1'b1};
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

FILE: sv/mvsd_decode.sv
// Combinational segment decode of one virtual address under the current mode.
// Depends on mvsd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mvsd_decode
    import mvsd_pkg::*;
(
    input  wire logic [VADDR_W-1:0]  vaddr,
    input  wire logic [STATUS_W-1:0] status_bits,
    output seg_result_t              result
);

    logic [3:0] mode;
    logic       user;
    logic       sup;
    logic       rsvd;
    logic       kern;
    logic       wide;
    logic       in_useg32;
    logic       in_xuseg;
    logic       in_xsseg;
    logic       in_ck;
    logic       in_cksseg;
    logic       in_xkphys;
    logic       in_xkseg;
    logic       hit;
    logic [SEG_ID_W-1:0] seg_id;

    assign mode = status_bits[4:1];
    assign user = (mode == MODE_USER);
    assign sup  = (mode == MODE_SUP);
    assign rsvd = (mode == MODE_RSVD);
    assign kern = !user && !sup;
    assign wide = (kern && !rsvd && status_bits[ST_KX]) ||
                  (sup && status_bits[ST_SX]) ||
                  (user && status_bits[ST_UX]);

    assign in_useg32 = (vaddr[63:31] == '0);
    assign in_xuseg  = (vaddr[63:40] == '0);
    assign in_xsseg  = (vaddr[63:40] == 24'h400000);
    assign in_ck     = &vaddr[63:31];
    assign in_cksseg = in_ck && (vaddr[30:29] == 2'b10);
    assign in_xkphys = (vaddr[63:62] == 2'b10) && (vaddr[58:32] == '0);
    assign in_xkseg  = (vaddr[63:40] == 24'hC00000) && !(&vaddr[39:31]);

    always_comb begin
        hit    = 1'b1;
        seg_id = SEG_USEG32;
        priority if (wide && in_xuseg) begin
            seg_id = SEG_XUSEG;
        end else if (!wide && in_useg32) begin
            seg_id = SEG_USEG32;
        end else if (user) begin
            hit = 1'b0;
        end else if (in_xsseg) begin
            seg_id = SEG_XSSEG;
        end else if (kern && in_ck) begin
            seg_id = SEG_CKSEG0 + {2'b00, vaddr[30:29]};
        end else if (kern && in_xkphys) begin
            seg_id = SEG_XKPHYS | {1'b0, vaddr[61:59]};
        end else if (kern && in_xkseg) begin
            seg_id = SEG_XKSEG;
        end else if (sup && in_cksseg) begin
            seg_id = SEG_CKSSEG;
        end else begin
            hit = 1'b0;
        end
    end

    always_comb begin
        result.hit    = hit;
        result.seg_id = hit ? seg_id : '0;
        result.desc   = hit ? seg_desc(seg_id) : '0;
    end

endmodule

`default_nettype wire

FILE: sv/mips_virtual_segment_decoder.sv
// Top level of the virtual address segment decoder: input register, decode,
// result register. Depends on mvsd_pkg and mvsd_decode.
`timescale 1ns / 1ps
`default_nettype none

// Decodes one 64-bit virtual address per request into its address segment
// under the mode given by status bits 7..1, and returns hit, segment number,
// mapped and cached flags, translation offset and privilege mask. One request
// is taken every cycle while s_ready is high; the request lands in the input
// register, and the decode stage fills the result register from it once that
// register can advance. A single decode stage lies between the two registers.
// A stalled result side holds back the input only once both registers are
// full; a miss returns all result fields at zero.
module mips_virtual_segment_decoder
    import mvsd_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output      logic                 s_ready,
    input  wire logic [VADDR_W-1:0]   s_vaddr,
    input  wire logic [STATUS_W-1:0]  s_status_bits,
    output      logic                 m_valid,
    input  wire logic                 m_ready,
    output      logic                 m_hit,
    output      logic [SEG_ID_W-1:0]  m_segment_id,
    output      logic                 m_is_mapped,
    output      logic                 m_is_cached,
    output      logic [VADDR_W-1:0]   m_phys_offset,
    output      logic [MASK_W-1:0]    m_priv_mask
);

    logic                in_valid_reg;
    logic [VADDR_W-1:0]  vaddr_reg;
    logic [STATUS_W-1:0] status_reg;
    logic                out_valid_reg;
    seg_result_t         res_reg;
    seg_result_t         res_next;
    logic                out_advance;
    logic                in_advance;

    // advance the result stage when it is empty or being drained
    assign out_advance = !out_valid_reg || m_ready;
    assign in_advance  = !in_valid_reg || out_advance;
    assign s_ready     = in_advance;

    mvsd_decode u_decode (
        .vaddr       (vaddr_reg),
        .status_bits (status_reg),
        .result      (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (in_advance) begin
                in_valid_reg <= s_valid;
            end
            if (out_advance) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && in_advance) begin
            vaddr_reg  <= s_vaddr;
            status_reg <= s_status_bits;
        end
        if (in_valid_reg && out_advance) begin
            res_reg <= res_next;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_hit         = res_reg.hit;
    assign m_segment_id  = res_reg.seg_id;
    assign m_is_mapped   = res_reg.desc.mapped;
    assign m_is_cached   = res_reg.desc.cached;
    assign m_phys_offset = res_reg.desc.offset;
    assign m_priv_mask   = res_reg.desc.mask;

`ifndef SYNTH
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_hit) |-> (m_segment_id == '0 && m_priv_mask == '0 &&
                                 m_phys_offset == '0 && !m_is_mapped && !m_is_cached))
        else $error("miss result carries non-zero fields");

    a_mapped_no_offset: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_hit && m_is_mapped) |-> (m_phys_offset == '0))
        else $error("mapped segment with translation offset");

    a_xkphys_kernel: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_hit && m_segment_id[3]) |-> (!m_is_mapped && m_priv_mask == PRIV_KERN))
        else $error("xkphys window decoded as mapped or non-kernel");

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !out_advance) |=> (in_valid_reg && $stable(vaddr_reg)))
        else $error("stalled request dropped from input register");

    a_result_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && out_advance) |=> out_valid_reg)
        else $error("decoded request not captured in result register");
`endif

endmodule

`default_nettype wire
